// ===== rtl/bba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and codes for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int REQ_SIZE_W  = 20;
   localparam int REQ_TDATA_W = 40;
   localparam int STATUS_W    = 3;

   typedef enum logic [1:0] {
      MARK_ABSENT = 2'd0,
      MARK_FREE   = 2'd1,
      MARK_ALLOC  = 2'd2,
      MARK_SPLIT  = 2'd3
   } mark_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ALLOCATED = 3'd0,
      ST_FREED     = 3'd1,
      ST_TOO_LARGE = 3'd2,
      ST_NO_SPACE  = 3'd3,
      ST_IGNORED   = 3'd4
   } rsp_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_A_READ,
      S_A_EVAL,
      S_A_SIB,
      S_A_FRESH,
      S_A_BACK,
      S_F_READ,
      S_F_EVAL,
      S_M_READ,
      S_M_EVAL,
      S_RESP
   } state_type;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_LEFT,
      IDX_TARGET,
      IDX_NEXT,
      IDX_UP
   } idx_op_type;

   typedef enum logic [1:0] {
      WR_IDX,
      WR_RCHILD,
      WR_PARENT
   } wr_sel_type;

   typedef enum logic {
      RD_IDX,
      RD_SIB
   } rd_sel_type;

   typedef struct packed {
      logic           load;
      logic           rd_en;
      rd_sel_type     rd_sel;
      logic           wr_en;
      wr_sel_type     wr_sel;
      mark_type       wr_mark;
      idx_op_type     idx_op;
      logic           res_load;
      rsp_status_type res_code;
      logic           rsp_push;
   } cmd_type;

   typedef struct packed {
      logic     mode;
      logic     too_large;
      logic     out_range;
      mark_type mark;
      logic     big;
      logic     at_root;
      logic     is_right;
      logic     at_bottom;
      logic     aligned;
      logic     rsp_busy;
   } sts_type;

endpackage

// ===== rtl/bba_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer for tree walks: allocate search, split, free lookup and merge.
// ----------------------------------------------------------------------------
module bba_ctrl
   import bba_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!sts.mode) state_in = sts.too_large ? S_RESP : S_A_EVAL;
            else           state_in = sts.out_range ? S_RESP : S_F_EVAL;
         end
         S_A_READ: state_in = S_A_EVAL;
         S_A_EVAL: begin
            if (sts.mark == MARK_ABSENT || sts.mark == MARK_ALLOC) begin
               state_in = S_A_BACK;
            end else if (sts.big) begin
               state_in = (sts.mark == MARK_SPLIT) ? S_A_BACK : S_RESP;
            end else if (sts.at_bottom) begin
               state_in = S_A_BACK;
            end else begin
               state_in = (sts.mark == MARK_FREE) ? S_A_SIB : S_A_READ;
            end
         end
         S_A_SIB:   state_in = S_A_FRESH;
         S_A_FRESH: state_in = sts.big ? S_RESP : S_A_SIB;
         S_A_BACK: begin
            if (sts.at_root)       state_in = S_RESP;
            else if (!sts.is_right) state_in = S_A_READ;
         end
         S_F_READ: state_in = S_F_EVAL;
         S_F_EVAL: begin
            if (sts.mark == MARK_SPLIT) begin
               state_in = sts.at_bottom ? S_RESP : S_F_READ;
            end else if (sts.mark == MARK_ALLOC && sts.aligned) begin
               state_in = S_M_READ;
            end else begin
               state_in = S_RESP;
            end
         end
         S_M_READ: state_in = sts.at_root ? S_RESP : S_M_EVAL;
         S_M_EVAL: state_in = (sts.mark == MARK_FREE) ? S_M_READ : S_RESP;
         S_RESP: begin
            if (!sts.rsp_busy) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.rd_sel   = RD_IDX;
      cmd.wr_sel   = WR_IDX;
      cmd.wr_mark  = MARK_FREE;
      cmd.idx_op   = IDX_HOLD;
      cmd.res_code = ST_IGNORED;
      req_ready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            // no request is taken while reset is held
            req_ready = !reset;
            cmd.load  = req_valid && !reset;
         end
         S_CHECK: begin
            if (!sts.mode) begin
               if (sts.too_large) begin
                  cmd.res_load = 1'b1;
                  cmd.res_code = ST_TOO_LARGE;
               end else begin
                  cmd.rd_en = 1'b1;
               end
            end else if (sts.out_range) begin
               cmd.res_load = 1'b1;
               cmd.res_code = ST_IGNORED;
            end else begin
               cmd.rd_en = 1'b1;
            end
         end
         S_A_READ, S_F_READ: cmd.rd_en = 1'b1;
         S_A_EVAL: begin
            if (sts.mark == MARK_FREE && sts.big) begin
               cmd.wr_en    = 1'b1;
               cmd.wr_mark  = MARK_ALLOC;
               cmd.res_load = 1'b1;
               cmd.res_code = ST_ALLOCATED;
            end else if (!sts.big && !sts.at_bottom) begin
               if (sts.mark == MARK_FREE) begin
                  cmd.wr_en   = 1'b1;
                  cmd.wr_mark = MARK_SPLIT;
               end else if (sts.mark == MARK_SPLIT) begin
                  cmd.idx_op = IDX_LEFT;
               end
            end
         end
         S_A_SIB: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_RCHILD;
            cmd.wr_mark = MARK_FREE;
            cmd.idx_op  = IDX_LEFT;
         end
         S_A_FRESH: begin
            cmd.wr_en = 1'b1;
            if (sts.big) begin
               cmd.wr_mark  = MARK_ALLOC;
               cmd.res_load = 1'b1;
               cmd.res_code = ST_ALLOCATED;
            end else begin
               cmd.wr_mark = MARK_SPLIT;
            end
         end
         S_A_BACK: begin
            if (sts.at_root) begin
               cmd.res_load = 1'b1;
               cmd.res_code = ST_NO_SPACE;
            end else begin
               cmd.idx_op = sts.is_right ? IDX_UP : IDX_NEXT;
            end
         end
         S_F_EVAL: begin
            if (sts.mark == MARK_SPLIT) begin
               if (sts.at_bottom) begin
                  cmd.res_load = 1'b1;
                  cmd.res_code = ST_IGNORED;
               end else begin
                  cmd.idx_op = IDX_TARGET;
               end
            end else if (sts.mark == MARK_ALLOC && sts.aligned) begin
               cmd.wr_en    = 1'b1;
               cmd.wr_mark  = MARK_FREE;
               cmd.res_load = 1'b1;
               cmd.res_code = ST_FREED;
            end else begin
               cmd.res_load = 1'b1;
               cmd.res_code = ST_IGNORED;
            end
         end
         S_M_READ: begin
            if (!sts.at_root) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_SIB;
            end
         end
         S_M_EVAL: begin
            if (sts.mark == MARK_FREE) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = WR_PARENT;
               cmd.wr_mark = MARK_FREE;
               cmd.idx_op  = IDX_UP;
            end
         end
         S_RESP: cmd.rsp_push = !sts.rsp_busy;
         default: ;
      endcase
   end

endmodule

// ===== rtl/bba_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_datapath
// Node cursor, node mark memory, request capture and response registers.
// ----------------------------------------------------------------------------
module bba_datapath
   import bba_pkg::*;
#(
   parameter int POOL_LOG2      = 19,
   parameter int MIN_BLOCK_LOG2 = 12,
   parameter int RSP_TDATA_W    = 40
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_mode,
   input  logic [REQ_SIZE_W-1:0]  req_size,
   input  logic [REQ_SIZE_W-1:0]  req_offset,
   input  cmd_type                cmd,
   output sts_type                sts,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [RSP_TDATA_W-1:0] rsp_data
);

   localparam int LEVELS = POOL_LOG2 - MIN_BLOCK_LOG2;
   localparam int IW     = LEVELS + 1;
   localparam int DW     = $clog2(LEVELS + 1);
   localparam int OW     = POOL_LOG2;
   localparam int CW     = (POOL_LOG2 + 1 > REQ_SIZE_W) ? POOL_LOG2 + 1 : REQ_SIZE_W;
   localparam int SHW    = $clog2(POOL_LOG2 + 1);
   localparam int PAD    = RSP_TDATA_W - 2 * OW - 1;
   localparam int DEPTH  = 1 << IW;
   localparam logic [CW-1:0] POOL_BYTES = CW'(1) << POOL_LOG2;
   localparam logic [CW-1:0] POOL_HALF  = CW'(1) << (POOL_LOG2 - 1);
   localparam logic [CW-1:0] MIN_BYTES  = CW'(1) << MIN_BLOCK_LOG2;
   localparam logic [IW-1:0] ROOT       = IW'(1);

   logic                  mode_ff;
   logic [REQ_SIZE_W-1:0] size_ff, target_ff;
   logic [IW-1:0]         idx_ff, idx_in;
   logic [DW-1:0]         dep_ff, dep_in;

   mark_type              mem [DEPTH];
   mark_type              mem_rd_ff;
   mark_type              root_ff;
   logic                  rd_root_ff;
   logic [IW-1:0]         rd_addr, wr_addr;

   logic [STATUS_W-1:0]   res_status_ff;
   logic [OW-1:0]         res_off_ff;
   logic [OW:0]           res_size_ff;
   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   logic [CW-1:0] size_cw, target_cw, half, blk, off_cw;
   logic [IW-1:0] idx_rel;
   logic [SHW-1:0] off_sh;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff   <= req_mode;
         size_ff   <= req_size;
         target_ff <= req_offset;
      end
   end

   assign size_cw   = (CW'(size_ff) < MIN_BYTES) ? MIN_BYTES : CW'(size_ff);
   assign target_cw = CW'(target_ff);
   assign half      = POOL_HALF >> dep_ff;
   assign blk       = POOL_BYTES >> dep_ff;
   assign idx_rel   = idx_ff ^ (ROOT << dep_ff);
   assign off_sh    = SHW'(POOL_LOG2) - SHW'(dep_ff);
   assign off_cw    = CW'(idx_rel) << off_sh;

   // node cursor
   always_comb begin
      idx_in = idx_ff;
      dep_in = dep_ff;
      if (cmd.load) begin
         idx_in = ROOT;
         dep_in = '0;
      end else begin
         case (cmd.idx_op)
            IDX_LEFT: begin
               idx_in = {idx_ff[IW-2:0], 1'b0};
               dep_in = dep_ff + DW'(1);
            end
            IDX_TARGET: begin
               idx_in = {idx_ff[IW-2:0], (target_cw & half) != '0};
               dep_in = dep_ff + DW'(1);
            end
            IDX_NEXT: idx_in = idx_ff + ROOT;
            IDX_UP: begin
               idx_in = idx_ff >> 1;
               dep_in = dep_ff - DW'(1);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      dep_ff <= dep_in;
   end

   // mark memory; the root lives in a flop so reset needs no clearing pass
   assign rd_addr = (cmd.rd_sel == RD_SIB) ? (idx_ff ^ ROOT) : idx_ff;

   always_comb begin
      case (cmd.wr_sel)
         WR_RCHILD: wr_addr = {idx_ff[IW-2:0], 1'b1};
         WR_PARENT: wr_addr = idx_ff >> 1;
         default:   wr_addr = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff <= MARK_FREE;
      end else if (cmd.wr_en && wr_addr == ROOT) begin
         root_ff <= cmd.wr_mark;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en && wr_addr != ROOT) begin
         mem[wr_addr] <= cmd.wr_mark;
      end
      if (cmd.rd_en) begin
         mem_rd_ff  <= mem[rd_addr];
         rd_root_ff <= (rd_addr == ROOT);
      end
   end

   // result staging and output register
   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         res_status_ff <= cmd.res_code;
         if (cmd.res_code == ST_ALLOCATED || cmd.res_code == ST_FREED) begin
            res_off_ff  <= off_cw[OW-1:0];
            res_size_ff <= blk[OW:0];
         end else begin
            res_off_ff  <= '0;
            res_size_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_push) begin
         rsp_status_ff <= res_status_ff;
         rsp_data_ff   <= {PAD'(0), res_size_ff, res_off_ff};
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      sts           = '0;
      sts.mode      = mode_ff;
      sts.too_large = size_cw > POOL_BYTES;
      sts.out_range = target_cw >= POOL_BYTES;
      sts.mark      = rd_root_ff ? root_ff : mem_rd_ff;
      sts.big       = size_cw > half;
      sts.at_root   = idx_ff == ROOT;
      sts.is_right  = idx_ff[0];
      sts.at_bottom = dep_ff == DW'(LEVELS);
      sts.aligned   = (target_cw & (blk - CW'(1))) == '0;
      sts.rsp_busy  = rsp_valid_ff && !rsp_ready;
   end

endmodule

// ===== rtl/buddy_block_allocator_core.sv =====
`timescale 1ns / 1ps
// Too large and out of range requests go straight to the response; an allocate searches
//   the tree from the root, left first, over L = POOL_LOG2 - MIN_BLOCK_LOG2 tree levels.
// A free walks down to its block and, when it is freed, merges free buddies upward.
// Throughput: one request in flight; the next is taken the cycle after the response loads.
// Reset: synchronous, clears the sequencer and response valid; the root is a free block.
// ----------------------------------------------------------------------------
// buddy_block_allocator_core
// Buddy allocator over a 2^POOL_LOG2 byte pool with 2^MIN_BLOCK_LOG2 minimum blocks.
// ----------------------------------------------------------------------------
module buddy_block_allocator_core
   import bba_pkg::*;
#(
   parameter int POOL_LOG2      = 19,
   parameter int MIN_BLOCK_LOG2 = 12,
   // response payload: offset (POOL_LOG2 bits) then size (POOL_LOG2+1), rounded to bytes
   localparam int RSP_TDATA_W   = ((2 * POOL_LOG2 + 1 + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_TDATA_W-1:0]    req_tdata,  // request_size[19:0], free_offset[39:20]
   input  logic                      req_tuser,  // mode: 0 allocate, 1 free
   // response channel
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_W-1:0]    rsp_tdata,  // block_offset, block_size, zero pad
   output logic [STATUS_W-1:0]       rsp_tuser   // status
);

   cmd_type cmd;
   sts_type sts;

   // sequencer: walks the tree, one mark read or write per step
   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // cursor, marks and result registers
   bba_datapath #(
      .POOL_LOG2      (POOL_LOG2),
      .MIN_BLOCK_LOG2 (MIN_BLOCK_LOG2),
      .RSP_TDATA_W    (RSP_TDATA_W)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_mode   (req_tuser),
      .req_size   (req_tdata[REQ_SIZE_W-1:0]),
      .req_offset (req_tdata[2*REQ_SIZE_W-1:REQ_SIZE_W]),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_status (rsp_tuser),
      .rsp_data   (rsp_tdata)
   );

endmodule

// ===== sim/tb_buddy_block_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_buddy_block_allocator_core
// Self-checking bench for the buddy allocator. A short directed table covers
// size extremes, oversize requests, no-space and ignored frees. It is followed
// by random allocate/free traffic that mostly frees blocks still held. Every
// response is checked against an in-bench model of the node tree.
// ----------------------------------------------------------------------------
module tb_buddy_block_allocator_core;
   import bba_pkg::*;

   localparam int POOL_LOG2   = 19;
   localparam int MIN_LOG2    = 12;
   localparam int LEVELS      = POOL_LOG2 - MIN_LOG2;
   localparam int NODES       = (1 << (LEVELS + 1)) - 1;
   localparam int POOL_BYTES  = 1 << POOL_LOG2;
   localparam int MIN_BYTES   = 1 << MIN_LOG2;
   localparam int N_RANDOM    = 1230;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      rsp_status_type status;
      logic [18:0]    offset;
      logic [19:0]    size;
   } result_t;

   typedef struct {
      logic        mode;
      logic [19:0] req_size;
      logic [19:0] offset;
      bit          typed;
      result_t     result;
   } row_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;  // request_size[19:0], free_offset[39:20]
   logic                   req_tuser = 1'b0; // mode
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [39:0]            rsp_tdata;  // block_offset[18:0], block_size[38:19], pad
   logic [STATUS_W-1:0]    rsp_tuser;  // status

   mark_type    marks [1:NODES];
   result_t     pending [$];
   int unsigned held_offsets [$];
   int          send_idle_pct, recv_stall_pct;
   int          mismatches, idle_cycles;

   buddy_block_allocator_core u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // left-first search; returns heap index of the block taken, 0 if none fits
   function automatic int unsigned take_block(int unsigned idx, int depth, int unsigned sz);
      int unsigned half, got;
      if (idx > NODES || depth > LEVELS) return 0;
      if (marks[idx] == MARK_ALLOC || marks[idx] == MARK_ABSENT) return 0;
      half = (POOL_BYTES >> depth) >> 1;
      if (sz > half) begin
         if (marks[idx] == MARK_SPLIT) return 0;
         marks[idx] = MARK_ALLOC;
         return idx;
      end
      if (depth >= LEVELS) return 0;
      if (marks[idx] != MARK_SPLIT) begin
         marks[idx]         = MARK_SPLIT;
         marks[2*idx]       = MARK_FREE;
         marks[2*idx + 1]   = MARK_FREE;
      end
      got = take_block(2*idx, depth + 1, sz);
      if (got != 0) return got;
      return take_block(2*idx + 1, depth + 1, sz);
   endfunction

   function automatic result_t allocate_or_free(logic mode, logic [19:0] rsz,
                                                logic [19:0] foff);
      result_t     r;
      int unsigned sz, idx, noff, par;
      int          d;
      r = '{ST_IGNORED, '0, '0};
      if (!mode) begin
         sz = (rsz < MIN_BYTES) ? MIN_BYTES : rsz;
         if (sz > POOL_BYTES) r.status = ST_TOO_LARGE;
         else begin
            idx = take_block(1, 0, sz);
            if (idx == 0) r.status = ST_NO_SPACE;
            else begin
               d = 0;
               while ((idx >> (d + 1)) != 0) d++;
               r.status = ST_ALLOCATED;
               r.offset = 19'((idx - (1 << d)) << (POOL_LOG2 - d));
               r.size   = 20'(POOL_BYTES >> d);
            end
         end
      end else if (foff < POOL_BYTES) begin
         idx = 1;
         d   = 0;
         forever begin
            noff = (idx - (1 << d)) << (POOL_LOG2 - d);
            if (marks[idx] != MARK_SPLIT) begin
               if (marks[idx] == MARK_ALLOC && noff == foff) begin
                  marks[idx] = MARK_FREE;
                  r = '{ST_FREED, 19'(noff), 20'(POOL_BYTES >> d)};
                  // merge free buddies upward
                  while (idx > 1) begin
                     par = idx >> 1;
                     if (marks[2*par] != MARK_FREE || marks[2*par + 1] != MARK_FREE) break;
                     marks[2*par]     = MARK_ABSENT;
                     marks[2*par + 1] = MARK_ABSENT;
                     marks[par]       = MARK_FREE;
                     idx = par;
                  end
               end
               break;
            end
            if (d >= LEVELS) break;
            idx = (foff < noff + ((POOL_BYTES >> d) >> 1)) ? 2*idx : 2*idx + 1;
            d++;
         end
      end
      return r;
   endfunction

   // drive one request, wait for acceptance, then log its expected response
   task automatic issue(logic mode, logic [19:0] rsz, logic [19:0] foff,
                        bit typed, result_t typed_res);
      result_t r;
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = mode;
      req_tdata  = {foff, rsz};
      do @(posedge clock); while (!req_tready);
      r = allocate_or_free(mode, rsz, foff);
      if (r.status == ST_ALLOCATED) held_offsets.push_back(32'(r.offset));
      if (r.status == ST_FREED)
         foreach (held_offsets[i])
            if (held_offsets[i] == r.offset) begin
               held_offsets.delete(i);
               break;
            end
      pending.push_back(typed ? typed_res : r);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // receiver back-pressure
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   // response checker
   always @(posedge clock) begin
      result_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_status_type'(rsp_tuser), rsp_tdata[18:0], rsp_tdata[38:19]};
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
         end else begin
            want = pending.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %s off %0d size %0d, got %s off %0d size %0d",
                           want.status.name(), want.offset, want.size,
                           got.status.name(), got.offset, got.size);
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_buddy_block_allocator_core failed");
         $finish;
      end
   end

   initial begin
      row_t        rows [$];
      int unsigned e, sz, pick;
      int          r;
      mismatches  = 0;
      idle_cycles = 0;
      send_idle_pct  = 38;
      recv_stall_pct = 65;
      foreach (marks[i]) marks[i] = MARK_ABSENT;
      marks[1] = MARK_FREE;

      // directed table; typed rows hold hand-written expectations
      rows = '{
         '{1'b0, 20'd0,       20'd0,       1, '{ST_ALLOCATED, 19'd0, 20'd4096}},
         '{1'b0, 20'd524289,  20'd0,       1, '{ST_TOO_LARGE, 19'd0, 20'd0}},
         '{1'b0, 20'hFFFFF,   20'hFFFFF,   1, '{ST_TOO_LARGE, 19'd0, 20'd0}},
         '{1'b1, 20'hFFFFF,   20'd524288,  1, '{ST_IGNORED,   19'd0, 20'd0}},
         '{1'b1, 20'd0,       20'hFFFFF,   1, '{ST_IGNORED,   19'd0, 20'd0}},
         '{1'b1, 20'd0,       20'd4095,    1, '{ST_IGNORED,   19'd0, 20'd0}},
         '{1'b1, 20'd0,       20'd0,       1, '{ST_FREED,     19'd0, 20'd4096}},
         '{1'b1, 20'd0,       20'd0,       1, '{ST_IGNORED,   19'd0, 20'd0}},
         '{1'b0, 20'd524288,  20'd0,       1, '{ST_ALLOCATED, 19'd0, 20'd524288}},
         '{1'b0, 20'd1,       20'd0,       1, '{ST_NO_SPACE,  19'd0, 20'd0}},
         '{1'b1, 20'd0,       20'd0,       1, '{ST_FREED,     19'd0, 20'd524288}},
         '{1'b0, 20'd4097,    20'd0,       0, '{ST_IGNORED, 19'd0, 20'd0}},
         '{1'b0, 20'd4096,    20'd0,       0, '{ST_IGNORED, 19'd0, 20'd0}},
         '{1'b0, 20'd262144,  20'd0,       0, '{ST_IGNORED, 19'd0, 20'd0}},
         '{1'b0, 20'd262145,  20'd0,       0, '{ST_IGNORED, 19'd0, 20'd0}},
         '{1'b1, 20'd0,       20'd8192,    0, '{ST_IGNORED, 19'd0, 20'd0}},
         '{1'b1, 20'd0,       20'd4096,    0, '{ST_IGNORED, 19'd0, 20'd0}},
         '{1'b1, 20'd0,       20'd262144,  0, '{ST_IGNORED, 19'd0, 20'd0}},
         '{1'b1, 20'd0,       20'd0,       0, '{ST_IGNORED, 19'd0, 20'd0}},
         '{1'b1, 20'd0,       20'd524287,  0, '{ST_IGNORED, 19'd0, 20'd0}}
      };

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i])
         issue(rows[i].mode, rows[i].req_size, rows[i].offset, rows[i].typed, rows[i].result);

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM / 3) begin
            send_idle_pct  = 65;
            recv_stall_pct = 38;
         end else if (n == 2 * N_RANDOM / 3) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         r = $urandom_range(99);
         if (r < 8) begin
            // noise: any field value at all
            issue(1'($urandom_range(1)), 20'($urandom), 20'($urandom), 0, '0);
         end else if (held_offsets.size() > 0 && (r < 50 || held_offsets.size() > 40)) begin
            pick = held_offsets[$urandom_range(held_offsets.size() - 1)];
            issue(1'b1, 20'($urandom), 20'(pick), 0, '0);
         end else begin
            // mostly small blocks, now and then up to the whole pool
            e  = ($urandom_range(9) == 0) ? $urandom_range(POOL_LOG2, 17)
                                           : $urandom_range(16, MIN_LOG2);
            sz = (1 << e) - $urandom_range((1 << (e - 1)) - 1);
            issue(1'b0, 20'(sz), 20'($urandom), 0, '0);
         end
      end

      wait (pending.size() == 0);
      repeat (600) @(posedge clock);
      if (mismatches == 0 && pending.size() == 0)
         $display("tb_buddy_block_allocator_core passed");
      else
         $display("tb_buddy_block_allocator_core failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/bba_pkg.sv
rtl/bba_ctrl.sv
rtl/bba_datapath.sv
rtl/buddy_block_allocator_core.sv
sim/tb_buddy_block_allocator_core.sv
